@@ rtl/core/kss_pkg.sv @@
// kss_pkg: shared types and constants for the kmp substring search unit
// payload structs for both channels, status and command codes, cell control struct
// no dependencies
package kss_pkg;

   localparam int MAX_PATTERN_DEF = 64;
   localparam int BYTE_W          = 8;
   localparam int POS_W           = 32;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef enum logic {
      CMD_PATTERN = 1'b0,
      CMD_TEXT    = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_NOT_FOUND = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      command_type       command;
      logic              first;
      logic              last;
      logic [BYTE_W-1:0] byte_value;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] position;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              step;       // advance the match bits by one text byte
      logic              clr;        // drop all partial matches
      logic              pat_clear;  // drop the stored pattern
      logic [BYTE_W-1:0] data;       // byte of the current transfer
   } cell_ctrl_type;

endpackage

@@ rtl/core/kss_stream_if.sv @@
// kss_stream_if: valid/ready channel carrying one payload per transfer
// payload type is a parameter, normally a struct from kss_pkg
interface kss_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/kss_cell.sv @@
// kss_cell: one position of the pattern chain
// holds a pattern byte, its valid flag and the prefix match bit; uses kss_pkg
module kss_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  kss_pkg::cell_ctrl_type ctrl,
   input  logic                  wr_en,
   input  logic                  chain_in,
   input  logic                  next_valid,
   output logic                  valid_out,
   output logic                  match_out,
   output logic                  hit
);

   logic [kss_pkg::BYTE_W-1:0] byte_ff;
   logic                       valid_ff;
   logic                       valid_in;
   logic                       match_ff;
   logic                       match_in;
   logic                       match_new;

   // prefix ending here matches if the shorter one matched on the previous byte
   assign match_new = valid_ff & chain_in & (byte_ff == ctrl.data);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in = 1'b1;
      end else if (ctrl.pat_clear) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      match_in = match_ff;
      if (ctrl.clr) begin
         match_in = 1'b0;
      end else if (ctrl.step) begin
         match_in = match_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_ff <= ctrl.data;
      end
   end

   assign valid_out = valid_ff;
   assign match_out = match_ff;
   // tail cell of the pattern with a full-length match
   assign hit       = match_new & ~next_valid;

endmodule

@@ rtl/core/kmp_substring_search_unit.sv @@
// kmp_substring_search_unit: streaming first-occurrence substring search
// top level; instantiates a chain of kss_cell, uses kss_pkg and kss_stream_if
//
// usage
//   req carries pattern bytes (command pattern) and text bytes (command text).
//   first on a pattern byte starts a new pattern; first on a text byte starts
//   a new search. last marks the final text byte.
//   rsp carries at most one result per search: found with the start index of
//   the first match, not found at the last text byte, or overflow when the
//   pattern lost bytes beyond MAX_PATTERN. an empty pattern is found at 0.
// timing
//   every request transfer is handled in the cycle it is taken; a result is
//   shown on rsp in the cycle after the transfer that caused it.
//   one request per cycle is taken while rsp is free or being drained: the
//   chain of cells compares all pattern positions against each text byte in
//   parallel and shifts the match bits one cell on.
//   a result held on a stalled rsp blocks req until it is taken.
// reset
//   synchronous; empties the pattern and the search state and drops any
//   pending result. pattern bytes themselves need no reset.
module kmp_substring_search_unit #(
   parameter int MAX_PATTERN = kss_pkg::MAX_PATTERN_DEF
) (
   input logic          clock,
   input logic          reset,
   kss_stream_if.sink   req,
   kss_stream_if.source rsp
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   // pattern and search state
   logic [LEN_W-1:0]          len_ff;
   logic [LEN_W-1:0]          len_in;
   logic                      ovf_ff;
   logic                      ovf_in;
   logic                      done_ff;
   logic                      done_in;
   logic [kss_pkg::POS_W-1:0] idx_ff;
   logic [kss_pkg::POS_W-1:0] idx_in;

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   kss_pkg::rsp_type          rsp_data_ff;
   kss_pkg::rsp_type          rsp_data_in;

   // transfer decode
   kss_pkg::req_type          cur;
   logic                      fire;
   logic                      is_pat;
   logic                      is_txt;
   logic [LEN_W-1:0]          len_base;
   logic                      full;
   logic                      done_eff;
   logic [kss_pkg::POS_W-1:0] idx_eff;
   logic [kss_pkg::POS_W-1:0] idx_next;
   logic [kss_pkg::POS_W-1:0] match_pos;
   logic                      step;
   logic                      found;
   logic                      emit;
   kss_pkg::rsp_type          emit_data;
   kss_pkg::cell_ctrl_type    ctrl;

   // chain wiring
   logic [MAX_PATTERN-1:0]    wr_vec;
   logic [MAX_PATTERN-1:0]    chain_vec;
   logic [MAX_PATTERN-1:0]    next_valid_vec;
   logic [MAX_PATTERN-1:0]    valid_vec;
   logic [MAX_PATTERN-1:0]    match_vec;
   logic [MAX_PATTERN-1:0]    hit_vec;

   assign cur       = req.payload;
   assign req.ready = ~rsp_valid_ff | rsp.ready;
   assign fire      = req.valid & req.ready;
   assign is_pat    = fire & (cur.command == kss_pkg::CMD_PATTERN);
   assign is_txt    = fire & (cur.command == kss_pkg::CMD_TEXT);

   // a new pattern restarts the append point at zero
   assign len_base  = (is_pat & cur.first) ? '0 : len_ff;
   assign full      = (len_base == LEN_W'(MAX_PATTERN));

   // first on either command also restarts the search
   assign done_eff  = cur.first ? 1'b0 : done_ff;
   assign idx_eff   = cur.first ? '0 : idx_ff;
   assign idx_next  = (idx_eff == kss_pkg::POS_MAX) ? idx_eff : idx_eff + 1'b1;

   // start index of a match ending at the current byte, saturated
   assign match_pos = (idx_eff == kss_pkg::POS_MAX) ? kss_pkg::POS_MAX
                    : idx_eff - (kss_pkg::POS_W'(len_ff) - 1'b1);

   assign step  = is_txt & ~done_eff & ~ovf_ff & (len_ff != '0);
   assign found = step & (|hit_vec);

   always_comb begin
      ctrl.step      = step;
      ctrl.clr       = fire & cur.first & ~step;
      ctrl.pat_clear = is_pat & cur.first;
      ctrl.data      = cur.byte_value;
   end

   // cell chain: bit i set means pattern prefix of length i+1 ends at the last byte
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      assign wr_vec[i] = is_pat & ~full & (len_base == LEN_W'(i));

      if (i == 0) begin : g_head
         assign chain_vec[i] = 1'b1;
      end else begin : g_body
         // a new text discards partial matches from the old one
         assign chain_vec[i] = match_vec[i-1] & ~cur.first;
      end

      if (i == MAX_PATTERN - 1) begin : g_tail
         assign next_valid_vec[i] = 1'b0;
      end else begin : g_inner
         assign next_valid_vec[i] = valid_vec[i+1];
      end

      kss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .wr_en      (wr_vec[i]),
         .chain_in   (chain_vec[i]),
         .next_valid (next_valid_vec[i]),
         .valid_out  (valid_vec[i]),
         .match_out  (match_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   // next state and result
   always_comb begin
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      done_in   = done_ff;
      idx_in    = idx_ff;
      emit      = 1'b0;
      emit_data = '{status: kss_pkg::STATUS_NOT_FOUND, position: '0};

      if (is_pat) begin
         len_in  = full ? len_base : len_base + 1'b1;
         ovf_in  = full | (cur.first ? 1'b0 : ovf_ff);
         done_in = done_eff;
         idx_in  = idx_eff;
      end else if (is_txt) begin
         done_in = done_eff;
         idx_in  = idx_eff;
         if (!done_eff) begin
            if (ovf_ff) begin
               emit             = 1'b1;
               emit_data.status = kss_pkg::STATUS_OVERFLOW;
               done_in          = 1'b1;
            end else if (len_ff == '0) begin
               // empty pattern matches at the start
               emit             = 1'b1;
               emit_data.status = kss_pkg::STATUS_FOUND;
               done_in          = 1'b1;
            end else if (found) begin
               emit               = 1'b1;
               emit_data.status   = kss_pkg::STATUS_FOUND;
               emit_data.position = match_pos;
               done_in            = 1'b1;
            end else begin
               idx_in = idx_next;
               if (cur.last) begin
                  emit    = 1'b1;
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp.ready);
      rsp_data_in  = emit ? emit_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         done_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         done_ff      <= done_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

`ifndef ASSERT_OFF
   // stored pattern cells are as many as the recorded length
   a_len_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(len_ff))
      else $error("pattern length disagrees with filled cells");

   // partial matches only live in filled cells
   a_match_in_pattern: assert property (@(posedge clock) disable iff (reset)
      (match_vec & ~valid_vec) == '0)
      else $error("match bit set beyond the pattern");

   // overflow only once the chain is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LEN_W'(MAX_PATTERN)))
      else $error("overflow flagged with room left");

   // every result ends its search
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      emit |=> (done_ff && rsp_valid_ff))
      else $error("result given without ending the search");
`endif

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for kmp_substring_search_unit
// drives pattern and text transfers, predicts first-match outcomes and checks rsp
// depends on kss_pkg, kss_stream_if and the unit itself
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = kss_pkg::MAX_PATTERN_DEF;
   // cycles with no transfer on either channel before the run is called hung
   localparam int STALL_LIMIT = 4000;
   // length of the forced receiver hold-off
   localparam int HOLD_CYCLES = 300;

   // tracks the pattern, its failure links and the running search, and keeps
   // the outcomes that the unit still owes
   class search_outcome_board;
      logic [kss_pkg::BYTE_W-1:0] pat_bytes [CAP];
      int                         fail_link [CAP];
      int                         pat_len;
      int                         build_k;
      int                         match_k;
      logic [kss_pkg::POS_W-1:0]  text_pos;
      bit                         done;
      bit                         overflowed;
      kss_pkg::rsp_type           pending_outcomes [$];
      int                         mismatches;

      function new();
         pat_len    = 0;
         build_k    = -1;
         overflowed = 1'b0;
         mismatches = 0;
         restart_search();
      endfunction

      function void restart_search();
         match_k  = -1;
         text_pos = '0;
         done     = 1'b0;
      endfunction

      function int clip(int i);
         if (i < 0) return 0;
         if (i >= CAP) return CAP - 1;
         return i;
      endfunction

      // follow failure links until b extends the prefix or none is left
      function int advance_prefix(int k, logic [kss_pkg::BYTE_W-1:0] b);
         int nk;
         while (k > -1 && pat_bytes[clip(k + 1)] != b) begin
            nk = fail_link[clip(k)];
            k  = (nk < k) ? nk : -1;
         end
         if (pat_bytes[clip(k + 1)] == b) k++;
         return k;
      endfunction

      function void conclude(kss_pkg::status_type s, logic [kss_pkg::POS_W-1:0] p);
         kss_pkg::rsp_type r;
         r.status   = s;
         r.position = p;
         pending_outcomes.push_back(r);
         done = 1'b1;
      endfunction

      function void note_request(kss_pkg::req_type r);
         if (r.command == kss_pkg::CMD_PATTERN) begin
            if (r.first) begin
               pat_len    = 0;
               build_k    = -1;
               overflowed = 1'b0;
               restart_search();
            end
            if (pat_len >= CAP) begin
               overflowed = 1'b1;
               return;
            end
            pat_bytes[pat_len] = r.byte_value;
            if (pat_len == 0) begin
               fail_link[0] = -1;
            end else begin
               build_k            = advance_prefix(build_k, r.byte_value);
               fail_link[pat_len] = build_k;
            end
            pat_len++;
            return;
         end
         if (r.first) restart_search();
         if (done) return;
         if (overflowed) begin
            conclude(kss_pkg::STATUS_OVERFLOW, '0);
            return;
         end
         if (pat_len == 0) begin
            conclude(kss_pkg::STATUS_FOUND, '0);
            return;
         end
         match_k = advance_prefix(match_k, r.byte_value);
         if (match_k == pat_len - 1) begin
            conclude(kss_pkg::STATUS_FOUND,
                     (text_pos == kss_pkg::POS_MAX) ? kss_pkg::POS_MAX
                                                    : text_pos - kss_pkg::POS_W'(match_k));
            return;
         end
         if (text_pos != kss_pkg::POS_MAX) text_pos++;
         if (r.last) conclude(kss_pkg::STATUS_NOT_FOUND, '0);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_outcome(kss_pkg::rsp_type got);
         kss_pkg::rsp_type want;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("unexpected result status %0d position %0d",
                             got.status, got.position));
            return;
         end
         want = pending_outcomes.pop_front();
         if (got.status !== want.status || got.position !== want.position)
            report($sformatf("status %0d position %0d, wanted status %0d position %0d",
                             got.status, got.position, want.status, want.position));
      endtask

      function int pending();
         return pending_outcomes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   kss_stream_if #(.payload_type(kss_pkg::req_type)) req_ch ();
   kss_stream_if #(.payload_type(kss_pkg::rsp_type)) rsp_ch ();

   kmp_substring_search_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   search_outcome_board board;

   int  burst_left   = 0;
   int  items_sent   = 0;
   int  idle_cycles  = 0;
   int  rx_cycle     = 0;
   int  rx_mode      = 0;
   int  hold_left    = 0;
   bit  hold_pending = 1'b0;

   always #1 clock = ~clock;

   // every accepted request feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) board.note_request(req_ch.payload);
   end

   // every accepted result is checked against the oldest outcome owed
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_outcome(rsp_ch.payload);
   end

   // receiver: the stall pattern is redrawn at random among four modes; a hold-off request from
   // the stimulus forces ready low for a long stretch
   always @(posedge clock) begin
      rx_cycle++;
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: begin
               rsp_ch.ready <= 1'b1;
            end
            1: begin
               rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ch.ready <= (rx_cycle % 7) >= 3;
            end
         endcase
      end
   end

   // watchdog: no transfer on either side for too long means a hang
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL kmp_substring_search_unit");
         $finish;
      end
   end

   // one request transfer; the sender works in bursts with idle gaps between
   task automatic send(input kss_pkg::command_type c, input logic f, input logic l,
                       input logic [kss_pkg::BYTE_W-1:0] b);
      kss_pkg::req_type item;
      int               gap;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      item.command    = c;
      item.first      = f;
      item.last       = l;
      item.byte_value = b;
      req_ch.payload <= item;
      req_ch.valid   <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      items_sent++;
   endtask

   // sender drops valid and pauses until every owed outcome has been taken, first
   // letting the last transfer reach the predictor
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // either a byte from a two-letter alphabet, so matches are common, or any byte
   function automatic logic [kss_pkg::BYTE_W-1:0] pick_byte(bit wide,
                                                           logic [kss_pkg::BYTE_W-1:0] a0,
                                                           logic [kss_pkg::BYTE_W-1:0] a1);
      if (wide) return kss_pkg::BYTE_W'($urandom_range(0, 255));
      return $urandom_range(0, 1) ? a1 : a0;
   endfunction

   initial begin
      logic [kss_pkg::BYTE_W-1:0] pat_q [$];
      logic [kss_pkg::BYTE_W-1:0] text_q [$];
      logic [kss_pkg::BYTE_W-1:0] a0;
      logic [kss_pkg::BYTE_W-1:0] a1;
      logic [kss_pkg::BYTE_W-1:0] hb;
      bit                         wide;
      int                         plen;
      int                         tlen;
      int                         at;
      int                         flavor;
      int                         roll;

      board = new();
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // empty pattern right after reset: found at 0, then the search is over
      send(kss_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h00);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b1, 8'hFF);
      // two-byte pattern at the byte extremes; last on a pattern byte is ignored
      send(kss_pkg::CMD_PATTERN, 1'b1, 1'b0, 8'hFF);
      send(kss_pkg::CMD_PATTERN, 1'b0, 1'b1, 8'h00);
      send(kss_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h00);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b0, 8'hFF);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b0, 8'hFF);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b1, 8'h00);
      // no match before last
      send(kss_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h00);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b1, 8'h00);
      // a new search finds the pattern at its start
      send(kss_pkg::CMD_TEXT, 1'b1, 1'b0, 8'hFF);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b1, 8'h00);
      // pattern grows while a search is running
      send(kss_pkg::CMD_PATTERN, 1'b1, 1'b0, 8'h41);
      send(kss_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h42);
      send(kss_pkg::CMD_PATTERN, 1'b0, 1'b0, 8'h43);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h41);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b1, 8'h43);
      // failure link fallback: aab inside aaab
      send(kss_pkg::CMD_PATTERN, 1'b1, 1'b0, 8'hAA);
      send(kss_pkg::CMD_PATTERN, 1'b0, 1'b0, 8'hAA);
      send(kss_pkg::CMD_PATTERN, 1'b0, 1'b0, 8'hAB);
      send(kss_pkg::CMD_TEXT, 1'b1, 1'b0, 8'hAA);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b0, 8'hAA);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b0, 8'hAA);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b1, 8'hAB);

      // full pattern plus one dropped byte, then an overflow search
      for (int i = 0; i <= CAP; i++)
         send(kss_pkg::CMD_PATTERN, i == 0, 1'($urandom_range(0, 1)),
              kss_pkg::BYTE_W'($urandom_range(0, 255)));
      send(kss_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h5A);
      send(kss_pkg::CMD_TEXT, 1'b0, 1'b1, 8'hA5);
      wait_drain();

      // --- back-pressure: receiver holds off while one-byte searches pile up ---
      hb = kss_pkg::BYTE_W'($urandom_range(0, 255));
      send(kss_pkg::CMD_PATTERN, 1'b1, 1'b0, hb);
      hold_pending = 1'b1;
      repeat (30) send(kss_pkg::CMD_TEXT, 1'b1, 1'b1, hb);
      wait_drain();

      // --- random part: well-formed pattern/text sequences with some noise ---
      while (items_sent < 1100) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            plen = $urandom_range(1, 6);
         else if (roll < 92)
            plen = $urandom_range(7, 40);
         else
            plen = $urandom_range(CAP - 4, CAP + 6);
         a0   = kss_pkg::BYTE_W'($urandom_range(0, 255));
         a1   = kss_pkg::BYTE_W'($urandom_range(0, 255));
         wide = ($urandom_range(0, 3) == 0);
         pat_q.delete();
         for (int i = 0; i < plen; i++) pat_q.push_back(pick_byte(wide, a0, a1));
         for (int i = 0; i < plen; i++)
            send(kss_pkg::CMD_PATTERN, i == 0, 1'($urandom_range(0, 1)), pat_q[i]);

         repeat ($urandom_range(1, 3)) begin
            tlen = $urandom_range(1, 30);
            text_q.delete();
            for (int i = 0; i < tlen; i++) text_q.push_back(pick_byte(wide, a0, a1));
            // plant the pattern somewhere half of the time
            if ($urandom_range(0, 1) && plen <= CAP) begin
               at = $urandom_range(0, text_q.size());
               for (int j = 0; j < plen; j++) text_q.insert(at + j, pat_q[j]);
            end
            // broken sequences: missing first, missing last, pattern byte mid-text
            flavor = $urandom_range(0, 19);
            for (int i = 0; i < text_q.size(); i++) begin
               if (flavor == 2 && i == text_q.size() / 2)
                  send(kss_pkg::CMD_PATTERN, 1'b0, 1'($urandom_range(0, 1)),
                       pick_byte(wide, a0, a1));
               send(kss_pkg::CMD_TEXT, (i == 0) && flavor != 0,
                    (i == text_q.size() - 1) && flavor != 1, text_q[i]);
            end
         end

         // raw noise: any field combination
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5))
               send(kss_pkg::command_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), kss_pkg::BYTE_W'($urandom_range(0, 255)));
         end

         if ($urandom_range(0, 11) == 0) wait_drain();
      end

      // --- wind down ---
      wait_drain();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0)
         $display("PASS kmp_substring_search_unit");
      else
         $display("FAIL kmp_substring_search_unit");
      $finish;
   end

endmodule
